>>> rtl/core/sid_pkg.sv
// Shared types and constants for the signed integer to decimal text converter.
package sid_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CharWidth  = 8;
  localparam int unsigned NumDigits  = 10;
  localparam int unsigned DigitIdxW  = $clog2(NumDigits);
  localparam int unsigned ShiftCntW  = $clog2(ValueWidth);

  localparam logic [CharWidth-1:0] CharZero  = 8'd48;
  localparam logic [CharWidth-1:0] CharNine  = 8'd57;
  localparam logic [CharWidth-1:0] CharMinus = 8'd45;

  typedef logic [3:0] bcd_digit_t;
  typedef bcd_digit_t [NumDigits-1:0] bcd_word_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_LEAD = 5'b00100,
    ST_SIGN = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;        // capture input, clear BCD and shift count
    logic shift;       // one adjust-and-shift step
    logic load_idx;    // latch index of leading digit
    logic emit_sign;   // load '-' into output register
    logic emit_digit;  // load current digit, step index down
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic shift_done;  // current shift is the last one
    logic negative;
    logic idx_zero;    // current digit is the least significant one
    logic out_free;    // output register can take a character
  } dp_status_t;

endpackage

>>> rtl/core/sid_if.sv
// Valid/ready channel interfaces for input values and output characters.
interface sid_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [sid_pkg::ValueWidth-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sid_out_if;
  logic                            valid;
  logic                            ready;
  logic [sid_pkg::CharWidth-1:0]   char_code;
  logic                            is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

>>> rtl/core/sid_datapath.sv
// Datapath: magnitude, shift-add-3 BCD conversion, digit select and output register.
module sid_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  sid_pkg::dp_cmd_t                      cmd,
  output sid_pkg::dp_status_t                   status,
  input  logic signed [sid_pkg::ValueWidth-1:0] value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [sid_pkg::CharWidth-1:0]         char_code,
  output logic                                  is_last
);

  logic                              negative;
  logic [sid_pkg::ValueWidth-1:0]    bin;
  sid_pkg::bcd_word_t                bcd;
  logic [sid_pkg::ShiftCntW-1:0]     shift_cnt;
  logic [sid_pkg::DigitIdxW-1:0]     idx;

  sid_pkg::bcd_word_t                bcd_adj;
  logic [sid_pkg::DigitIdxW-1:0]     lead_idx;
  logic [sid_pkg::ValueWidth-1:0]    raw;

  assign raw = $unsigned(value);

  always_comb begin
    for (int i = 0; i < sid_pkg::NumDigits; i++) begin
      bcd_adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
  end

  // Highest nonzero digit; zero value falls back to the lowest digit.
  always_comb begin
    lead_idx = '0;
    for (int i = 0; i < sid_pkg::NumDigits; i++) begin
      if (bcd[i] != 4'd0) begin
        lead_idx = i[sid_pkg::DigitIdxW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      negative <= raw[sid_pkg::ValueWidth-1];
      bin      <= raw[sid_pkg::ValueWidth-1] ? (~raw + 1'b1) : raw;
      bcd      <= '0;
    end else if (cmd.shift) begin
      {bcd, bin} <= {bcd_adj[sid_pkg::NumDigits-1:0], bin} << 1;
    end
    if (cmd.load_idx) begin
      idx <= lead_idx;
    end else if (cmd.emit_digit) begin
      idx <= idx - 1'b1;
    end
    if (cmd.emit_sign) begin
      char_code <= sid_pkg::CharMinus;
      is_last   <= 1'b0;
    end else if (cmd.emit_digit) begin
      char_code <= sid_pkg::CharZero + {4'd0, bcd[idx]};
      is_last   <= (idx == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        shift_cnt <= '0;
      end else if (cmd.shift) begin
        shift_cnt <= shift_cnt + 1'b1;
      end
      if (cmd.emit_sign || cmd.emit_digit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.shift_done = (shift_cnt == '1);
  assign status.negative   = negative;
  assign status.idx_zero   = (idx == '0);
  assign status.out_free   = !out_valid || out_ready;

endmodule

>>> rtl/core/sid_ctrl.sv
// Controller: sequences capture, conversion, sign and digit emission.
module sid_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sid_pkg::dp_status_t status,
  output sid_pkg::dp_cmd_t    cmd
);

  sid_pkg::state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      sid_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = sid_pkg::ST_CONV;
        end
      end
      sid_pkg::ST_CONV: begin
        cmd.shift = 1'b1;
        if (status.shift_done) begin
          state_next = sid_pkg::ST_LEAD;
        end
      end
      sid_pkg::ST_LEAD: begin
        cmd.load_idx = 1'b1;
        state_next   = status.negative ? sid_pkg::ST_SIGN : sid_pkg::ST_EMIT;
      end
      sid_pkg::ST_SIGN: begin
        if (status.out_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = sid_pkg::ST_EMIT;
        end
      end
      sid_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit_digit = 1'b1;
          if (status.idx_zero) begin
            state_next = sid_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = sid_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sid_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/core/signed_int_to_decimal_ascii_core.sv
// Top level: signed 32-bit integer to decimal ASCII text, one character per transfer.
// Sequence: after the input transfer the block captures the value, runs 32 shift-add-3
//   steps in the BCD converter, picks the leading digit, then registers the first character.
// Values: a new value is taken only once the last of its N characters (1..11) has been
//   loaded; the output register takes one character per cycle unless the receiver stalls.
// Reset: synchronous, active high; controller returns to idle, output goes invalid.
module signed_int_to_decimal_ascii_core (
  input  logic             clk,
  input  logic             rst,
  sid_in_if.sink           req,
  sid_out_if.source        rsp
);

  sid_pkg::dp_cmd_t    cmd;
  sid_pkg::dp_status_t status;

  // Controller: accept one value, run the conversion, then walk the digits.
  sid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: holds magnitude and BCD digits, drives the output register.
  sid_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .value     (req.value),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .char_code (rsp.char_code),
    .is_last   (rsp.is_last)
  );

  // Every character shown is a minus sign or a decimal digit.
  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.char_code == sid_pkg::CharMinus ||
                   (rsp.char_code >= sid_pkg::CharZero &&
                    rsp.char_code <= sid_pkg::CharNine)))
    else $error("output character outside sign and digit set");

  // The minus sign never ends a string.
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.char_code == sid_pkg::CharMinus) |-> !rsp.is_last)
    else $error("minus sign flagged as last character");

  // After an input transfer the block stops taking values while it converts.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("input taken again during conversion");

  // Never overwrite a character that is still waiting to be taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_sign || cmd.emit_digit) |-> (!rsp.valid || rsp.ready))
    else $error("output register overwritten while stalled");

endmodule

>>> tb/sid_text_checker.sv
// Checker for the decimal text converter: predicts each character and compares output transfers.
module sid_text_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic signed [sid_pkg::ValueWidth-1:0] in_value,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic [sid_pkg::CharWidth-1:0]         out_char,
  input  logic                                  out_last,
  output int                                    mismatch_count,
  output int                                    pending,
  output int                                    values_seen,
  output int                                    chars_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [sid_pkg::CharWidth-1:0] code;
    logic                          last;
  } text_char_t;

  // Characters still owed by the block, oldest first.
  text_char_t expected_text[$];

  // Append the decimal spelling of one value to the expected text.
  task automatic predict_text(input logic [sid_pkg::ValueWidth-1:0] raw);
    logic [31:0] mag;
    logic [31:0] rem;
    logic [3:0]  digits [sid_pkg::NumDigits];
    int          ndig;
    text_char_t  ch;
    // Unsigned negation gives 2147483648 for the most negative value.
    mag  = raw[31] ? (32'd0 - raw) : raw;
    ndig = 0;
    do begin
      rem          = mag % 32'd10;
      digits[ndig] = rem[3:0];
      mag          = mag / 32'd10;
      ndig++;
    end while (mag != 32'd0 && ndig < sid_pkg::NumDigits);
    if (raw[31]) begin
      ch.code = sid_pkg::CharMinus;
      ch.last = 1'b0;
      expected_text.push_back(ch);
    end
    for (int k = ndig - 1; k >= 0; k--) begin
      ch.code = sid_pkg::CharZero + {4'd0, digits[k]};
      ch.last = (k == 0);
      expected_text.push_back(ch);
    end
  endtask

  always @(posedge clk) begin
    text_char_t want;
    if (rst) begin
      mismatch_count = 0;
      values_seen    = 0;
      chars_seen     = 0;
      expected_text.delete();
    end else begin
      // Retire the output transfer first, so a character that arrives with no
      // expectation is never matched against a value taken at the same edge.
      if (out_valid && out_ready) begin
        chars_seen++;
        if (expected_text.size() == 0) begin
          $error("char_code: expected none, got %0d (is_last %0d)", out_char, out_last);
          mismatch_count++;
        end else begin
          want = expected_text.pop_front();
          if (out_char !== want.code) begin
            $error("char_code: expected %0d, got %0d", want.code, out_char);
            mismatch_count++;
          end
          if (out_last !== want.last) begin
            $error("is_last: expected %0d, got %0d", want.last, out_last);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        values_seen++;
        predict_text(in_value);
      end
    end
    pending = expected_text.size();
  end

endmodule

>>> tb/tb.sv
// Testbench top: clock, reset, stimulus and verdict for the decimal text converter.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkHalf        = 6;
  localparam int ResetCycles    = 4;
  localparam int RandomPerPhase = 87;
  localparam int SettleCycles   = 60;
  localparam int RunLimit       = 1_000_000;

  logic clk = 1'b0;
  logic rst;

  // Idle odds in percent, changed per phase: sender gaps and receiver stalls.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_count    = 0;

  int mismatch_count;
  int pending;
  int values_seen;
  int chars_seen;

  sid_in_if  req_ch ();
  sid_out_if rsp_ch ();

  signed_int_to_decimal_ascii_core uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  sid_text_checker text_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (req_ch.valid),
    .in_ready       (req_ch.ready),
    .in_value       (req_ch.value),
    .out_valid      (rsp_ch.valid),
    .out_ready      (rsp_ch.ready),
    .out_char       (rsp_ch.char_code),
    .out_last       (rsp_ch.is_last),
    .mismatch_count (mismatch_count),
    .pending        (pending),
    .values_seen    (values_seen),
    .chars_seen     (chars_seen)
  );

  always begin
    #ClkHalf clk = 1'b1;
    #ClkHalf clk = 1'b0;
  end

  // Hard stop: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RunLimit) begin
      $display("FAIL signed_int_to_decimal_ascii_core");
      $finish;
    end
  end

  // Receiver: drop ready at random, once per cycle, at the current stall odds.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one value and hold it until the block takes the transfer. Valid is
  // left high afterwards; the next call either keeps it up or drops it for a gap,
  // so each edge sees a single assignment to valid.
  task automatic send_value(input logic signed [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.value <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Draw a value: a quarter are raw 32-bit patterns so every bit toggles,
  // the rest pick a digit count first so short and long strings are both common.
  function automatic logic signed [31:0] random_value();
    longint lo;
    longint hi;
    longint mag;
    int     ndig;
    logic   neg;
    if ($urandom_range(3) == 0) return $urandom();
    ndig = $urandom_range(1, 10);
    lo   = 1;
    for (int i = 1; i < ndig; i++) lo = lo * 10;
    hi   = lo * 10 - 1;
    if (ndig == 1) lo = 0;
    if (hi > 64'sd2147483648) hi = 64'sd2147483648;
    mag  = lo + (longint'($urandom()) % (hi - lo + 1));
    neg  = 1'($urandom_range(1));
    // The magnitude 2147483648 exists only as the most negative value.
    if (mag == 64'sd2147483648) neg = 1'b1;
    if (neg) mag = -mag;
    return mag[31:0];
  endfunction

  initial begin
    req_ch.valid <= 1'b0;
    req_ch.value <= '0;
    rst          <= 1'b1;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero, single digits, the digit-count boundaries 9/10, 99/100 and
    // 999999999/1000000000, both extremes of the field, and alternating bit patterns.
    send_value(32'sd0);
    send_value(32'sd1);
    send_value(-32'sd1);
    send_value(32'sd9);
    send_value(-32'sd9);
    send_value(32'sd10);
    send_value(-32'sd10);
    send_value(32'sd99);
    send_value(32'sd100);
    send_value(-32'sd100);
    send_value(32'sd999999999);
    send_value(32'sd1000000000);
    send_value(-32'sd1000000000);
    send_value(32'sd1234567890);
    send_value(-32'sd1234567890);
    send_value(32'sh5555_5555);
    send_value(32'shAAAA_AAAA);
    send_value(32'sh7FFF_FFFF);
    send_value(-32'sh7FFF_FFFF);
    send_value(32'sh8000_0000);
    send_value(32'sd7);

    // Random: advance through the idle mixes, clean first, then sender gaps,
    // then receiver stalls, then light gaps on both sides.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 76;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 76;
        end
        default: begin
          send_idle_pct  = 7;
          recv_stall_pct = 7;
        end
      endcase
      repeat (RandomPerPhase) send_value(random_value());
    end
    req_ch.valid <= 1'b0;

    // Drain: wait for every owed character, then give the block time to show
    // anything extra.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("Converted %0d values into %0d characters, zero and both 32-bit extremes",
             values_seen, chars_seen);
    $display("included, under clean flow, sender gaps, receiver stalls and mixed idling.");
    if (mismatch_count == 0 && pending == 0) begin
      $display("PASS signed_int_to_decimal_ascii_core");
    end else begin
      $display("FAIL signed_int_to_decimal_ascii_core");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/sid_pkg.sv
rtl/core/sid_if.sv
rtl/core/sid_datapath.sv
rtl/core/sid_ctrl.sv
rtl/core/signed_int_to_decimal_ascii_core.sv
tb/sid_text_checker.sv
tb/tb.sv
